// File: src/clpe_pkg.sv
// Shared types and constants for the circular list engine.
// Used by every module of the block; depends on nothing.
package clpe_pkg;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 48;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_HEAD = 3'd0,
    KIND_INS_TAIL = 3'd1,
    KIND_INS_POS  = 3'd2,
    KIND_DEL_HEAD = 3'd3,
    KIND_DEL_TAIL = 3'd4,
    KIND_DEL_POS  = 3'd5,
    KIND_READ_ALL = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_NEGPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_INS  = 2'd0,
    OP_DEL  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_WALK,
    ST_DEL_FIN,
    ST_INS_A,
    ST_INS_B,
    ST_RD_ISSUE,
    ST_RD_EMIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic next_we;
    logic data_we;
  } mem_ctl_t;

  typedef struct packed {
    logic take;
    logic free_en;
  } slot_ctl_t;

  typedef struct packed {
    logic [COUNT_W-1:0]       count;
    logic                     last;
    logic signed [DATA_W-1:0] item;
    status_e                  status;
  } result_t;

endpackage

// File: src/clpe_store.sv
// Slot store: link memory and item memory, one write and one read port each,
// read data registered. Depends on clpe_pkg.
module clpe_store
  import clpe_pkg::*;
#(
  parameter int unsigned CAPACITY = 32,
  localparam int unsigned SLOT_W = $clog2(CAPACITY)
) (
  input  logic                     clk_i,
  input  mem_ctl_t                 ctl_i,
  input  logic [SLOT_W-1:0]        waddr_i,
  input  logic [SLOT_W-1:0]        wnext_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  input  logic [SLOT_W-1:0]        raddr_i,
  output logic [SLOT_W-1:0]        rnext_o,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic [SLOT_W-1:0]        next_ram_q [CAPACITY];
  logic signed [DATA_W-1:0] data_ram_q [CAPACITY];
  logic [SLOT_W-1:0]        rnext_q;
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.next_we) begin
      next_ram_q[waddr_i] <= wnext_i;
    end
    if (ctl_i.data_we) begin
      data_ram_q[waddr_i] <= wdata_i;
    end
    rnext_q <= next_ram_q[raddr_i];
    rdata_q <= data_ram_q[raddr_i];
  end

  assign rnext_o = rnext_q;
  assign rdata_o = rdata_q;

endmodule

// File: src/clpe_alloc.sv
// Slot-use bits and lowest-free-slot search.
// Depends on clpe_pkg.
module clpe_alloc
  import clpe_pkg::*;
#(
  parameter int unsigned CAPACITY = 32,
  localparam int unsigned SLOT_W = $clog2(CAPACITY)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slot_ctl_t         ctl_i,
  input  logic [SLOT_W-1:0] idx_i,
  output logic [SLOT_W-1:0] free_idx_o
);

  logic [CAPACITY-1:0] in_use_q, in_use_d;

  always_comb begin
    in_use_d = in_use_q;
    if (ctl_i.take) begin
      in_use_d[idx_i] = 1'b1;
    end
    if (ctl_i.free_en) begin
      in_use_d[idx_i] = 1'b0;
    end
  end

  // priority pick, lowest index wins
  always_comb begin
    free_idx_o = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx_o = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else begin
      in_use_q <= in_use_d;
    end
  end

endmodule

// File: src/clpe_seq.sv
// Request sequencer: decodes a request, walks the links through the store,
// writes back and hands results to the output register. Depends on clpe_pkg.
module clpe_seq
  import clpe_pkg::*;
#(
  parameter int unsigned CAPACITY = 32,
  localparam int unsigned SLOT_W = $clog2(CAPACITY),
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  logic [KIND_W-1:0]        kind_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [POS_W-1:0]  position_i,
  input  logic                     out_free_i,
  output logic                     res_valid_o,
  output result_t                  res_o,
  output mem_ctl_t                 mem_ctl_o,
  output logic [SLOT_W-1:0]        waddr_o,
  output logic [SLOT_W-1:0]        wnext_o,
  output logic signed [DATA_W-1:0] wdata_o,
  output logic [SLOT_W-1:0]        raddr_o,
  input  logic [SLOT_W-1:0]        rnext_i,
  input  logic signed [DATA_W-1:0] rdata_i,
  output slot_ctl_t                slot_ctl_o,
  output logic [SLOT_W-1:0]        slot_idx_o,
  input  logic [SLOT_W-1:0]        free_idx_i
);

  state_e                   state_q, state_d;
  op_e                      op_q, op_d;
  status_e                  status_q, status_d;
  logic [SLOT_W-1:0]        cur_q, cur_d;
  logic [SLOT_W-1:0]        steps_q, steps_d;
  logic [SLOT_W-1:0]        prev_q, prev_d;
  logic [SLOT_W-1:0]        succ_q, succ_d;   // successor on insert, victim on delete
  logic [SLOT_W-1:0]        new_q, new_d;
  logic [SLOT_W-1:0]        tail_q, tail_d;
  logic [SLOT_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     tail_upd_q, tail_upd_d;
  logic signed [DATA_W-1:0] value_q, value_d;

  kind_e              kind;
  logic               accept;
  logic               is_ins, is_del, is_rd;
  logic               neg_rej, full, empty;
  logic               ins_go, del_go, rd_go, del_single;
  logic [COUNT_W-1:0] cnt7, pos_mag, ins_k, del_k, k_sel;
  logic               at_end;
  logic               rd_last;
  status_e            early_status;

  assign kind    = kind_e'(kind_i);
  assign accept  = req_valid_i && (state_q == ST_IDLE);
  assign is_ins  = (kind == KIND_INS_HEAD) || (kind == KIND_INS_TAIL) ||
                   (kind == KIND_INS_POS);
  assign is_del  = (kind == KIND_DEL_HEAD) || (kind == KIND_DEL_TAIL) ||
                   (kind == KIND_DEL_POS);
  assign is_rd   = (kind == KIND_READ_ALL);
  assign neg_rej = ((kind == KIND_INS_POS) || (kind == KIND_DEL_POS)) &&
                   position_i[POS_W-1];
  assign full    = (cnt_q == CNT_W'(CAPACITY));
  assign empty   = (cnt_q == '0);

  assign ins_go     = is_ins && !neg_rej && !full;
  assign del_go     = is_del && !neg_rej && !empty;
  assign rd_go      = is_rd && !empty;
  assign del_single = del_go && (cnt_q == CNT_W'(1));

  assign cnt7    = COUNT_W'(cnt_q);
  assign pos_mag = position_i[COUNT_W-1:0];
  assign ins_k   = (pos_mag > cnt7) ? cnt7 : pos_mag;
  assign del_k   = (pos_mag >= cnt7) ? '0 : pos_mag;

  always_comb begin
    case (kind)
      KIND_INS_TAIL: k_sel = cnt7;
      KIND_INS_POS:  k_sel = ins_k;
      KIND_DEL_TAIL: k_sel = cnt7 - COUNT_W'(1);
      KIND_DEL_POS:  k_sel = del_k;
      default:       k_sel = '0;
    endcase
  end

  assign at_end  = (k_sel == cnt7);
  assign rd_last = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);

  always_comb begin
    if (neg_rej) begin
      early_status = STATUS_NEGPOS;
    end else if (is_ins && full) begin
      early_status = STATUS_FULL;
    end else if ((is_del || is_rd) && empty) begin
      early_status = STATUS_EMPTY;
    end else begin
      early_status = STATUS_OK;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (ins_go && empty) begin
            state_d = ST_INS_A;
          end else if (ins_go || (del_go && !del_single) || rd_go) begin
            state_d = ST_LOOK;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_LOOK: state_d = ST_WALK;
      ST_WALK: begin
        if (steps_q == '0) begin
          case (op_q)
            OP_INS:  state_d = ST_INS_A;
            OP_DEL:  state_d = ST_DEL_FIN;
            default: state_d = ST_RD_ISSUE;
          endcase
        end
      end
      ST_DEL_FIN:  state_d = ST_RESP;
      ST_INS_A:    state_d = ST_INS_B;
      ST_INS_B:    state_d = ST_RESP;
      ST_RD_ISSUE: state_d = ST_RD_EMIT;
      ST_RD_EMIT: begin
        if (out_free_i) begin
          state_d = rd_last ? ST_IDLE : ST_RD_ISSUE;
        end
      end
      ST_RESP: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_d       = op_q;
    status_d   = status_q;
    cur_d      = cur_q;
    steps_d    = steps_q;
    prev_d     = prev_q;
    succ_d     = succ_q;
    new_d      = new_q;
    tail_d     = tail_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    tail_upd_d = tail_upd_q;
    value_d    = value_q;

    mem_ctl_o   = '0;
    waddr_o     = prev_q;
    wnext_o     = new_q;
    wdata_o     = value_q;
    raddr_o     = cur_q;
    slot_ctl_o  = '0;
    slot_idx_o  = new_q;
    res_valid_o = 1'b0;
    res_o       = '{count: COUNT_W'(cnt_q), last: 1'b1, item: '0, status: status_q};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          value_d  = value_i;
          status_d = early_status;
          cur_d    = tail_q;
          new_d    = free_idx_i;
          steps_d  = '0;
          if (ins_go) begin
            op_d       = OP_INS;
            tail_upd_d = at_end;
            steps_d    = at_end ? '0 : SLOT_W'(k_sel);
            if (empty) begin
              prev_d = free_idx_i;
              succ_d = free_idx_i;
            end
          end else if (del_single) begin
            slot_ctl_o.free_en = 1'b1;
            slot_idx_o         = tail_q;
            cnt_d              = '0;
            tail_d             = '0;
          end else if (del_go) begin
            op_d    = OP_DEL;
            steps_d = SLOT_W'(k_sel);
          end else if (rd_go) begin
            op_d = OP_READ;
          end
        end
      end
      ST_WALK: begin
        if (steps_q != '0) begin
          cur_d   = rnext_i;
          raddr_o = rnext_i;
          steps_d = steps_q - SLOT_W'(1);
        end else begin
          case (op_q)
            OP_INS: begin
              prev_d = cur_q;
              succ_d = rnext_i;
            end
            OP_DEL: begin
              prev_d  = cur_q;
              succ_d  = rnext_i;
              raddr_o = rnext_i;   // fetch the victim's link
            end
            default: begin
              cur_d = rnext_i;     // head
              idx_d = '0;
            end
          endcase
        end
      end
      ST_DEL_FIN: begin
        mem_ctl_o.next_we  = 1'b1;
        waddr_o            = prev_q;
        wnext_o            = rnext_i;
        slot_ctl_o.free_en = 1'b1;
        slot_idx_o         = succ_q;
        cnt_d              = cnt_q - CNT_W'(1);
        if (succ_q == tail_q) begin
          tail_d = prev_q;
        end
      end
      ST_INS_A: begin
        mem_ctl_o.next_we = 1'b1;
        mem_ctl_o.data_we = 1'b1;
        waddr_o           = new_q;
        wnext_o           = succ_q;
      end
      ST_INS_B: begin
        mem_ctl_o.next_we = 1'b1;
        waddr_o           = prev_q;
        wnext_o           = new_q;
        slot_ctl_o.take   = 1'b1;
        cnt_d             = cnt_q + CNT_W'(1);
        if (tail_upd_q) begin
          tail_d = new_q;
        end
      end
      ST_RD_EMIT: begin
        res_valid_o = 1'b1;
        res_o = '{count: COUNT_W'(cnt_q), last: rd_last, item: rdata_i, status: STATUS_OK};
        if (out_free_i) begin
          cur_d = rnext_i;
          idx_d = idx_q + SLOT_W'(1);
        end
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign req_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= OP_INS;
      status_q   <= STATUS_OK;
      cur_q      <= '0;
      steps_q    <= '0;
      prev_q     <= '0;
      succ_q     <= '0;
      new_q      <= '0;
      tail_q     <= '0;
      idx_q      <= '0;
      cnt_q      <= '0;
      tail_upd_q <= 1'b0;
      value_q    <= '0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      status_q   <= status_d;
      cur_q      <= cur_d;
      steps_q    <= steps_d;
      prev_q     <= prev_d;
      succ_q     <= succ_d;
      new_q      <= new_d;
      tail_q     <= tail_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      tail_upd_q <= tail_upd_d;
      value_q    <= value_d;
    end
  end

endmodule

// File: src/circular_list_positional_engine_core.sv
// Rejected requests, the unused kind and deleting the only item go from idle straight to
// the response state; insert into an empty list goes through INS_A and INS_B first. An
// insert or delete first walks its k links through the single read port of the link memory
// (one link per cycle). Read-out walks to the head, then fetches and emits each item in
// turn. One request at a time; the next is taken once its last result sits in the output
// register. Reset clears control and slot-use bits only; slot memories are not cleared.
module circular_list_positional_engine_core
  import clpe_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // value[31:0], position[39:32]
  input  logic [KIND_W-1:0]    s_axis_tuser,   // kind[2:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // status[1:0], item[33:2], count[40:34]
  output logic                 m_axis_tlast    // last
);

  localparam int unsigned SLOT_W = $clog2(CAPACITY);

  mem_ctl_t                 mem_ctl;
  slot_ctl_t                slot_ctl;
  logic [SLOT_W-1:0]        waddr, wnext, raddr, rnext, slot_idx, free_idx;
  logic signed [DATA_W-1:0] wdata, rdata;
  logic                     res_valid, out_free;
  result_t                  res;
  logic                     out_valid_q, out_valid_d;
  result_t                  out_res_q;

  clpe_store #(.CAPACITY(CAPACITY)) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wnext_i (wnext),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rnext_o (rnext),
    .rdata_o (rdata)
  );

  clpe_alloc #(.CAPACITY(CAPACITY)) u_alloc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (slot_ctl),
    .idx_i      (slot_idx),
    .free_idx_o (free_idx)
  );

  clpe_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .value_i     (s_axis_tdata[DATA_W-1:0]),
    .position_i  (s_axis_tdata[DATA_W+POS_W-1:DATA_W]),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_ctl_o   (mem_ctl),
    .waddr_o     (waddr),
    .wnext_o     (wnext),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rnext_i     (rnext),
    .rdata_i     (rdata),
    .slot_ctl_o  (slot_ctl),
    .slot_idx_o  (slot_idx),
    .free_idx_i  (free_idx)
  );

  // output register
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && out_free) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_res_q.last;
  assign m_axis_tdata  = {{(M_TDATA_W - COUNT_W - DATA_W - 2){1'b0}},
                          out_res_q.count, out_res_q.item, out_res_q.status};

endmodule

// File: src/clpe_checker.sv
// Port-level checks on the result stream of the circular list engine.
// Depends on clpe_pkg; bound to circular_list_positional_engine_core.
module clpe_checker
  import clpe_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  logic [1:0]         st;
  logic [DATA_W-1:0]  itm;
  logic [COUNT_W-1:0] cnt;

  assign st  = m_axis_tdata[1:0];
  assign itm = m_axis_tdata[DATA_W+1:2];
  assign cnt = m_axis_tdata[DATA_W+COUNT_W+1:DATA_W+2];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt <= COUNT_W'(CAPACITY))
    else $error("count above capacity");

  a_reject_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st != STATUS_OK |-> m_axis_tlast && itm == '0)
    else $error("rejected request not a single empty result");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == STATUS_FULL |-> cnt == COUNT_W'(CAPACITY))
    else $error("full status with spare slots");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == STATUS_EMPTY |-> cnt == '0)
    else $error("empty status with items held");

endmodule

bind circular_list_positional_engine_core clpe_checker #(.CAPACITY(CAPACITY)) u_clpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
